FILE: rtl/core/psu_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and filter codes for the scanline unfilter.
package psu_pkg;

    localparam int MAX_ROW_BYTES   = 8192;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int COL_W  = 14;
    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int BPP_W  = 4;
    localparam int HIST_W = $clog2(MAX_PIXEL_BYTES);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 1'd1;

    localparam logic [7:0] FILTER_NONE  = 8'd0;
    localparam logic [7:0] FILTER_SUB   = 8'd1;
    localparam logic [7:0] FILTER_UP    = 8'd2;
    localparam logic [7:0] FILTER_AVG   = 8'd3;
    localparam logic [7:0] FILTER_PAETH = 8'd4;

    typedef enum logic [2:0] {
        FLT_NONE,
        FLT_SUB,
        FLT_UP,
        FLT_AVG,
        FLT_PAETH,
        FLT_BAD
    } filter_kind_t;

    // One classified data byte on its way to the reconstruction stage
    typedef struct packed {
        logic [7:0]       data;
        logic [COL_W-1:0] column;
        filter_kind_t     kind;
        logic             first_row;
        logic             row_end;
    } entry_t;

endpackage

FILE: rtl/core/psu_front.sv
`timescale 1ns / 1ps
// Front end: takes stream bytes, tracks row position and classifies data bytes.
module psu_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  in_byte,
    input  logic                        image_start,
    input  logic [psu_pkg::COL_W-1:0]   row_bytes,
    input  logic                        q_full,
    output logic                        push,
    output psu_pkg::entry_t             push_item
);
    import psu_pkg::*;

    logic               want_filter_reg, want_filter_next;
    logic               first_row_reg, first_row_next;
    filter_kind_t       kind_reg, kind_next;
    logic [COL_W-1:0]   column_reg, column_next;
    filter_kind_t       decoded_kind;
    logic               accept;
    logic               last_byte;
    logic [COL_W:0]     column_inc;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign push       = accept && !want_filter_reg;
    assign column_inc = {1'b0, column_reg} + (COL_W+1)'(1);
    assign last_byte  = column_inc >= {1'b0, row_bytes};

    always_comb
    begin
        unique case (in_byte)
            FILTER_NONE:  decoded_kind = FLT_NONE;
            FILTER_SUB:   decoded_kind = FLT_SUB;
            FILTER_UP:    decoded_kind = FLT_UP;
            FILTER_AVG:   decoded_kind = FLT_AVG;
            FILTER_PAETH: decoded_kind = FLT_PAETH;
            default:      decoded_kind = FLT_BAD;
        endcase
    end

    always_comb
    begin
        push_item.data      = in_byte;
        push_item.column    = column_reg;
        push_item.kind      = kind_reg;
        push_item.first_row = first_row_reg;
        push_item.row_end   = last_byte;
    end

    always_comb
    begin
        want_filter_next = want_filter_reg;
        first_row_next   = first_row_reg;
        kind_next        = kind_reg;
        column_next      = column_reg;
        if (accept)
        begin
            if (want_filter_reg)
            begin
                kind_next        = decoded_kind;
                first_row_next   = first_row_reg || image_start;
                want_filter_next = 1'b0;
                column_next      = '0;
            end
            else if (last_byte)
            begin
                column_next      = '0;
                want_filter_next = 1'b1;
                first_row_next   = 1'b0;
            end
            else
            begin
                column_next = column_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_filter_reg <= 1'b1;
            first_row_reg   <= 1'b1;
            kind_reg        <= FLT_NONE;
            column_reg      <= '0;
        end
        else
        begin
            want_filter_reg <= want_filter_next;
            first_row_reg   <= first_row_next;
            kind_reg        <= kind_next;
            column_reg      <= column_next;
        end
    end

    // after the last byte of a row the next byte must be taken as a filter code
    a_row_end_wants_filter: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_item.row_end |=> want_filter_reg)
        else $error("row end did not rearm filter byte");

endmodule

FILE: rtl/core/psu_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified data bytes between the front and back ends.
module psu_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  psu_pkg::entry_t     push_item,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output psu_pkg::entry_t     head
);
    import psu_pkg::*;

    entry_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

FILE: rtl/core/psu_back.sv
`timescale 1ns / 1ps
// Back end: line store read, filter reconstruction and output register.
module psu_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  psu_pkg::entry_t             head,
    output logic                        pop,
    input  logic [psu_pkg::BPP_W-1:0]   bpp,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        row_end,
    output logic                        bad_filter
);
    import psu_pkg::*;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic [9:0] sum_ab;
        logic [9:0] two_c;
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        sum_ab = 10'(a) + 10'(b);
        two_c  = {1'b0, c, 1'b0};
        pa     = (b >= c) ? 10'(b - c) : 10'(c - b);
        pb     = (a >= c) ? 10'(a - c) : 10'(c - a);
        pc     = (sum_ab >= two_c) ? (sum_ab - two_c) : (two_c - sum_ab);
        if (pa <= pb && pa <= pc)
            return a;
        else if (pb <= pc)
            return b;
        else
            return c;
    endfunction

    logic [7:0]         line_mem [MAX_ROW_BYTES];

    entry_t             rd_item_reg;
    logic               rd_valid_reg;
    logic [7:0]         above_mem_reg;
    logic               fwd_reg;
    logic [7:0]         fwd_data_reg;
    logic [7:0]         left_hist_reg  [MAX_PIXEL_BYTES];
    logic [7:0]         uleft_hist_reg [MAX_PIXEL_BYTES];
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               row_end_reg;
    logic               bad_filter_reg;

    logic               advance;
    logic [HIST_W-1:0]  hist_idx;
    logic               has_left;
    logic [7:0]         a_byte;
    logic [7:0]         b_byte;
    logic [7:0]         c_byte;
    logic [8:0]         avg_sum;
    logic [7:0]         recon;

    assign advance  = rd_valid_reg && (!out_valid_reg || out_ready);
    assign pop      = !q_empty && (!rd_valid_reg || advance);
    assign hist_idx = HIST_W'(bpp - BPP_W'(1));
    assign has_left = rd_item_reg.column >= COL_W'(bpp);
    assign a_byte   = has_left ? left_hist_reg[hist_idx]  : 8'd0;
    assign c_byte   = has_left ? uleft_hist_reg[hist_idx] : 8'd0;
    // the byte just written for a one-byte row is not yet visible in the read data
    assign b_byte   = rd_item_reg.first_row ? 8'd0 :
                      (fwd_reg ? fwd_data_reg : above_mem_reg);
    assign avg_sum  = 9'(a_byte) + 9'(b_byte);

    always_comb
    begin
        unique case (rd_item_reg.kind)
            FLT_NONE:  recon = rd_item_reg.data;
            FLT_SUB:   recon = rd_item_reg.data + a_byte;
            FLT_UP:    recon = rd_item_reg.data + b_byte;
            FLT_AVG:   recon = rd_item_reg.data + avg_sum[8:1];
            FLT_PAETH: recon = rd_item_reg.data + paeth(a_byte, b_byte, c_byte);
            default:   recon = rd_item_reg.data;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            line_mem[rd_item_reg.column[ADDR_W-1:0]] <= recon;
        if (pop)
            above_mem_reg <= line_mem[head.column[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_item_reg  <= head;
            fwd_data_reg <= recon;
        end
        if (advance)
        begin
            left_hist_reg[0]  <= recon;
            uleft_hist_reg[0] <= b_byte;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i]  <= left_hist_reg[i-1];
                uleft_hist_reg[i] <= uleft_hist_reg[i-1];
            end
            out_byte_reg   <= recon;
            row_end_reg    <= rd_item_reg.row_end;
            bad_filter_reg <= rd_item_reg.kind == FLT_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                rd_valid_reg <= 1'b1;
                fwd_reg      <= advance && (head.column == rd_item_reg.column);
            end
            else if (advance)
            begin
                rd_valid_reg <= 1'b0;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign row_end    = row_end_reg;
    assign bad_filter = bad_filter_reg;

    a_rd_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg && !advance |=> rd_valid_reg && rd_item_reg == $past(rd_item_reg))
        else $error("stalled byte lost or changed");

endmodule

FILE: rtl/core/png_scanline_unfilter.sv
`timescale 1ns / 1ps
// PNG scanline unfilter top level: config registers, front end, queue, back end.
// Data path: an accepted data byte passes the queue, the back end's read register and the output register.
// Throughput: one byte per cycle, filter bytes included, while the queue has room and the output is
// not stalled; the back end's single line store read and write port per cycle sets that figure.
// Reset: control state cleared, registers to 1; the line store is not cleared.
module png_scanline_unfilter
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] in_byte
    input  logic                            s_axis_tuser,   // [0] image_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] out_byte
    output logic                            m_axis_tlast,
    output logic                            m_axis_tuser,   // [0] bad_filter
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import psu_pkg::*;

    logic [BPP_W-1:0]   bpp_reg;
    logic [COL_W-1:0]   row_bytes_reg;
    logic [BPP_W-1:0]   bpp_eff;
    logic [COL_W-1:0]   row_bytes_eff;

    logic               push;
    entry_t             push_item;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    entry_t             head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg       <= BPP_W'(1);
            row_bytes_reg <= COL_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BPP:       bpp_reg       <= cfg_data[BPP_W-1:0];
                CFG_ROW_BYTES: row_bytes_reg <= cfg_data[COL_W-1:0];
                default:       ;
            endcase
        end
    end

    // out-of-range settings clamp to the supported span
    always_comb
    begin
        if (bpp_reg == '0)
            bpp_eff = BPP_W'(1);
        else if (bpp_reg > BPP_W'(MAX_PIXEL_BYTES))
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        else
            bpp_eff = bpp_reg;

        if (row_bytes_reg == '0)
            row_bytes_eff = COL_W'(1);
        else if (row_bytes_reg > COL_W'(MAX_ROW_BYTES))
            row_bytes_eff = COL_W'(MAX_ROW_BYTES);
        else
            row_bytes_eff = row_bytes_reg;
    end

    psu_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .image_start (s_axis_tuser),
        .row_bytes   (row_bytes_eff),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    psu_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    psu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (head),
        .pop        (pop),
        .bpp        (bpp_eff),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .row_end    (m_axis_tlast),
        .bad_filter (m_axis_tuser)
    );

endmodule

FILE: tb/tb_png_scanline_unfilter.sv
`timescale 1ns / 1ps
// Self-checking testbench for png_scanline_unfilter: row streams against a scanline predictor.
module tb_png_scanline_unfilter;

    import psu_pkg::*;

    localparam int RUN_LIMIT = 3_000_000;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
        logic       bad;
    } pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic [3:0]            reg_bpp;
    logic [CFG_DATA_W-1:0] reg_row_bytes;
    logic [7:0]            line_store [MAX_ROW_BYTES];
    logic [7:0]            left_hist [MAX_PIXEL_BYTES];
    logic [7:0]            upper_left_hist [MAX_PIXEL_BYTES];
    int                    row_col;
    logic [7:0]            row_filter;
    bit                    want_filter;
    bit                    on_image_top;
    int                    line_len;   // entries of the line store written since reset

    pixel_t                expected_pixels [$];
    int                    fault_count;
    int                    bytes_sent;
    int                    cycle_count;
    bit                    source_gaps;
    bit                    sink_stalls;
    bit                    hold_sink;

    png_scanline_unfilter DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] image_start
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),   // [0] bad_filter
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pixel_stride();
        if (reg_bpp == 0)
            return 1;
        if (reg_bpp > MAX_PIXEL_BYTES)
            return MAX_PIXEL_BYTES;
        return int'(reg_bpp);
    endfunction

    function automatic int row_len_now();
        if (reg_row_bytes == 0)
            return 1;
        if (reg_row_bytes > MAX_ROW_BYTES)
            return MAX_ROW_BYTES;
        return int'(reg_row_bytes);
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int da;
        int db;
        int dc;
        da = int'(b) - int'(c);
        db = int'(a) - int'(c);
        dc = int'(a) + int'(b) - 2 * int'(c);
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc)
            return a;
        if (db <= dc)
            return b;
        return c;
    endfunction

    // Advances the scanline state by one stream byte; returns 1 when a pixel comes out.
    function automatic bit unfilter_step(input logic [7:0] x, input logic start,
                                         output pixel_t px);
        int                stride;
        int                i;
        logic [ADDR_W-1:0] col_idx;
        logic [HIST_W-1:0] hist_idx;
        logic [7:0]        a;
        logic [7:0]        b;
        logic [7:0]        c;
        logic [7:0]        r;
        logic [8:0]        sum;
        px = '0;
        if (want_filter)
        begin
            row_filter = x;
            if (start)
                on_image_top = 1'b1;
            want_filter = 1'b0;
            row_col = 0;
            for (i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist[i] = 8'd0;
                upper_left_hist[i] = 8'd0;
            end
            return 1'b0;
        end
        stride = pixel_stride();
        col_idx = ADDR_W'(row_col);
        hist_idx = HIST_W'(stride - 1);
        a = 8'd0;
        b = 8'd0;
        c = 8'd0;
        if (!on_image_top)
            b = line_store[col_idx];
        if (row_col >= stride)
        begin
            a = left_hist[hist_idx];
            c = upper_left_hist[hist_idx];
        end
        px.bad = 1'b0;
        case (row_filter)
            FILTER_NONE:  r = x;
            FILTER_SUB:   r = x + a;
            FILTER_UP:    r = x + b;
            FILTER_AVG:
            begin
                sum = {1'b0, a} + {1'b0, b};
                r = x + sum[8:1];
            end
            FILTER_PAETH: r = x + paeth_pick(a, b, c);
            default:
            begin
                r = x;
                px.bad = 1'b1;
            end
        endcase
        for (i = MAX_PIXEL_BYTES - 1; i > 0; i--)
        begin
            left_hist[i] = left_hist[i - 1];
            upper_left_hist[i] = upper_left_hist[i - 1];
        end
        left_hist[0] = r;
        upper_left_hist[0] = b;
        line_store[col_idx] = r;
        if (row_col + 1 > line_len)
            line_len = row_col + 1;
        px.pixel = r;
        if (row_col + 1 >= row_len_now())
        begin
            px.row_end = 1'b1;
            row_col = 0;
            want_filter = 1'b1;
            on_image_top = 1'b0;
        end
        else
        begin
            px.row_end = 1'b0;
            row_col++;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] x, input logic start);
        pixel_t px;
        int     gap;
        if (source_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tuser  <= start;
        do @(posedge clk); while (!s_axis_tready);
        if (unfilter_step(x, start, px))
            expected_pixels.insert(expected_pixels.size(), px);
        bytes_sent++;
    endtask

    // A row longer than the stored line forces a new image so no unwritten entry is read.
    task automatic send_row(input logic [7:0] flt, input logic start);
        int   n;
        int   k;
        logic mark;
        n = row_len_now();
        mark = start;
        if (!on_image_top && n > line_len)
            mark = 1'b1;
        send_byte(flt, mark);
        for (k = 0; k < n; k++)
            send_byte(pick_byte(), $urandom_range(0, 7) == 0);
    endtask

    // Filter bytes give no pixel, so allow for the pipeline after the last one.
    task automatic drain_pipeline();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_BPP)
            reg_bpp = value[3:0];
        else
            reg_row_bytes = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // upper bits of a pixel size write are junk and must be ignored
    task automatic configure(input int stride, input int row_len);
        write_reg(CFG_BPP, {10'($urandom), 4'(stride)});
        write_reg(CFG_ROW_BYTES, CFG_DATA_W'(row_len));
    endtask

    task automatic test_filter_kinds();
        configure(1, 3);
        send_byte(FILTER_NONE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_row(FILTER_SUB, 1'b0);
        send_row(FILTER_UP, 1'b0);
        send_row(FILTER_AVG, 1'b0);
        send_row(FILTER_PAETH, 1'b0);
        send_row(8'd5, 1'b0);
        send_row(8'hFF, 1'b0);
        drain_pipeline();
    endtask

    task automatic test_register_extremes();
        configure(0, 0);
        send_row(FILTER_SUB, 1'b0);
        send_row(FILTER_UP, 1'b0);
        send_row(FILTER_PAETH, 1'b0);
        drain_pipeline();
        configure(15, 20);
        send_row(FILTER_SUB, 1'b1);
        send_row(FILTER_PAETH, 1'b0);
        send_row(FILTER_AVG, 1'b0);
        drain_pipeline();
        configure(8, 1);
        send_row(FILTER_UP, 1'b0);
        drain_pipeline();
    endtask

    task automatic test_mid_row_change();
        int k;
        configure(2, 10);
        send_row(FILTER_NONE, 1'b1);
        send_byte(FILTER_PAETH, 1'b0);
        for (k = 0; k < 4; k++)
            send_byte(pick_byte(), 1'b0);
        drain_pipeline();
        write_reg(CFG_BPP, 14'd4);
        send_byte(pick_byte(), 1'b1);   // start mark on a data byte
        send_byte(pick_byte(), 1'b0);
        drain_pipeline();
        // shorter than the current column: the next byte closes the row
        write_reg(CFG_ROW_BYTES, 14'd3);
        send_byte(pick_byte(), 1'b0);
        send_row(FILTER_UP, 1'b0);
        drain_pipeline();
    endtask

    task automatic test_line_store_full();
        configure(4, 300);
        send_row(FILTER_SUB, 1'b1);
        drain_pipeline();
        send_row(FILTER_PAETH, 1'b0);
        drain_pipeline();
    endtask

    task automatic test_backpressure();
        int k;
        configure(3, 8);
        source_gaps = 1'b0;
        hold_sink = 1'b1;
        for (k = 0; k < 5; k++)
            send_row(8'($urandom_range(0, 4)), 1'b0);
        drain_pipeline();
        source_gaps = 1'b1;
    endtask

    task automatic test_random_rows(input int target);
        int stop_at;
        int pick;
        int len;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                drain_pipeline();
                if ($urandom_range(0, 1))
                    write_reg(CFG_BPP, 14'($urandom));
                if ($urandom_range(0, 1))
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 3)
                        len = 0;
                    else if (pick < 75)
                        len = $urandom_range(1, 16);
                    else if (pick < 95)
                        len = $urandom_range(17, 96);
                    else
                        len = $urandom_range(97, 400);
                    write_reg(CFG_ROW_BYTES, CFG_DATA_W'(len));
                end
            end
            if ($urandom_range(0, 9) == 0)
                send_row(8'($urandom_range(5, 255)), $urandom_range(0, 9) == 0);
            else
                send_row(8'($urandom_range(0, 4)), $urandom_range(0, 9) == 0);
        end
        drain_pipeline();
    endtask

    // Sink side: random stall bursts, and one long hold when asked.
    initial
    begin : sink_ready
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_sink = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 16);
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_pixels
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                if (fault_count < 10)
                    $display("unexpected pixel: data %02h last %b bad %b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                fault_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata !== want.pixel || m_axis_tlast !== want.row_end
                    || m_axis_tuser !== want.bad)
                begin
                    if (fault_count < 10)
                        $display("pixel mismatch: expected %02h/%b/%b got %02h/%b/%b",
                                 want.pixel, want.row_end, want.bad,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_BPP;
        cfg_data      = '0;
        reg_bpp       = 4'd1;
        reg_row_bytes = 14'd1;
        row_col       = 0;
        row_filter    = FILTER_NONE;
        want_filter   = 1'b1;
        on_image_top  = 1'b1;
        line_len      = 0;
        fault_count   = 0;
        bytes_sent    = 0;
        cycle_count   = 0;
        source_gaps   = 1'b1;
        sink_stalls   = 1'b1;
        hold_sink     = 1'b0;
        for (int i = 0; i < MAX_PIXEL_BYTES; i++)
        begin
            left_hist[i] = 8'd0;
            upper_left_hist[i] = 8'd0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_filter_kinds();
        test_register_extremes();
        test_mid_row_change();
        test_line_store_full();
        test_backpressure();
        test_random_rows(1000);
        // closing stretch at full rate
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_rows(150);

        if (fault_count == 0 && expected_pixels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
